@@ hdl/md5sh_pkg.sv @@
// Shared types, constants and round tables of the MD5 stream hasher.
`default_nettype none

package md5sh_pkg;

   // Item selector codes
   localparam logic [1:0] CMD_DATA    = 2'd0;
   localparam logic [1:0] CMD_FINISH  = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;

   // Result status codes
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   // Default queue depths
   localparam int CMD_DEPTH_DEFAULT = 2;
   localparam int RSP_DEPTH_DEFAULT = 4;

   // Command word from front end to back end
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } cmd_type;

   // Result word
   typedef struct packed {
      logic        status;
      logic [1:0]  word_index;
      logic [31:0] digest_word;
      logic        last_word;
   } rsp_type;

   localparam logic [31:0] CHAIN_INIT [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Rotate amount, indexed by {round group, round[1:0]}
   localparam logic [4:0] ROT_AMT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // Message word used by a round
   function automatic logic [3:0] msg_index(input logic [5:0] rnd);
      logic [3:0] lo;
      logic [3:0] idx;
      lo = rnd[3:0];
      case (rnd[5:4])
         2'd0:    idx = lo;
         2'd1:    idx = 4'(lo * 4'd5 + 4'd1);
         2'd2:    idx = 4'(lo * 4'd3 + 4'd5);
         default: idx = 4'(lo * 4'd7);
      endcase
      return idx;
   endfunction

endpackage

`default_nettype wire

@@ hdl/md5sh_fifo.sv @@
// Small register-based first-in first-out queue.
`default_nettype none

module md5sh_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ hdl/md5sh_front.sv @@
// Front end: takes input words, sorts out unused codes, queues commands.
`default_nettype none

module md5sh_front (
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire logic [1:0]           req_func,
   input  wire logic [7:0]           req_data_byte,
   output logic                      cmd_push,
   output md5sh_pkg::cmd_type        cmd,
   input  wire logic                 cmd_full
);

   logic keep;

   // unused selector is taken and dropped here
   assign keep      = (req_func != md5sh_pkg::CMD_UNUSED);
   assign req_full  = cmd_full;
   assign cmd_push  = req_push && !cmd_full && keep;

   // data byte only matters for data words
   always_comb begin
      cmd.kind      = req_func;
      cmd.data_byte = (req_func == md5sh_pkg::CMD_DATA) ? req_data_byte : '0;
   end

endmodule

`default_nettype wire

@@ hdl/md5sh_back.sv @@
// Back end: block buffer, chaining state, MD5 round unit and digest output.
`default_nettype none

module md5sh_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 cmd_empty,
   output logic                      cmd_pop,
   input  wire md5sh_pkg::cmd_type   cmd,
   input  wire logic                 rsp_full,
   output logic                      rsp_push,
   output md5sh_pkg::rsp_type        rsp
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ROUND = 4'b0010,
      S_ADD   = 4'b0100,
      S_EMIT  = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic [31:0] blk_ff [16];
   logic [31:0] blk_in [16];
   logic [63:0] bits_ff, bits_in;
   logic        finished_ff, finished_in;
   logic [5:0]  round_ff, round_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] a_in, b_in, c_in, d_in;
   logic        tail_ff, tail_in;
   logic        fin_ff, fin_in;
   logic [1:0]  idx_ff, idx_in;

   logic [5:0]  pos;
   logic [1:0]  grp;
   logic [31:0] f_val;
   logic [31:0] t_val;
   logic [63:0] rot_dbl;
   logic [31:0] b_next;
   logic [31:0] sum [4];

   assign pos = bits_ff[8:3];
   assign grp = round_ff[5:4];

   // one MD5 round
   always_comb begin
      case (grp)
         2'd0:    f_val = d_ff ^ (b_ff & (c_ff ^ d_ff));
         2'd1:    f_val = c_ff ^ (d_ff & (b_ff ^ c_ff));
         2'd2:    f_val = b_ff ^ c_ff ^ d_ff;
         default: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
      t_val   = a_ff + f_val + blk_ff[md5sh_pkg::msg_index(round_ff)]
                + md5sh_pkg::ROUND_K[round_ff];
      rot_dbl = {t_val, t_val} << md5sh_pkg::ROT_AMT[{grp, round_ff[1:0]}];
      b_next  = b_ff + rot_dbl[63:32];
   end

   // chaining sums after the last round
   always_comb begin
      sum[0] = chain_ff[0] + a_ff;
      sum[1] = chain_ff[1] + b_ff;
      sum[2] = chain_ff[2] + c_ff;
      sum[3] = chain_ff[3] + d_ff;
   end

   // sequencer
   always_comb begin
      logic [5:0] byte_pos;
      byte_pos    = '0;
      state_in    = state_ff;
      chain_in    = chain_ff;
      blk_in      = blk_ff;
      bits_in     = bits_ff;
      finished_in = finished_ff;
      round_in    = round_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      c_in        = c_ff;
      d_in        = d_ff;
      tail_in     = tail_ff;
      fin_in      = fin_ff;
      idx_in      = idx_ff;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      rsp.status      = md5sh_pkg::STATUS_OK;
      rsp.word_index  = idx_ff;
      rsp.digest_word = chain_ff[idx_ff];
      rsp.last_word   = (idx_ff == 2'd3);

      case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               case (cmd.kind)
                  md5sh_pkg::CMD_RESTART: begin
                     cmd_pop     = 1'b1;
                     chain_in    = md5sh_pkg::CHAIN_INIT;
                     bits_in     = '0;
                     finished_in = 1'b0;
                  end
                  md5sh_pkg::CMD_DATA, md5sh_pkg::CMD_FINISH: begin
                     if (finished_ff) begin
                        // rejected word: one status result
                        if (!rsp_full) begin
                           cmd_pop         = 1'b1;
                           rsp_push        = 1'b1;
                           rsp.status      = md5sh_pkg::STATUS_REJECT;
                           rsp.word_index  = 2'd0;
                           rsp.digest_word = '0;
                           rsp.last_word   = 1'b1;
                        end
                     end else if (cmd.kind == md5sh_pkg::CMD_DATA) begin
                        cmd_pop = 1'b1;
                        blk_in[pos[5:2]][{pos[1:0], 3'b000} +: 8] = cmd.data_byte;
                        bits_in = bits_ff + 64'd8;
                        if (pos == 6'd63) begin
                           a_in     = chain_ff[0];
                           b_in     = chain_ff[1];
                           c_in     = chain_ff[2];
                           d_in     = chain_ff[3];
                           round_in = '0;
                           tail_in  = 1'b0;
                           fin_in   = 1'b0;
                           state_in = S_ROUND;
                        end
                     end else begin
                        // finish: marker byte, zero fill, length if it fits
                        cmd_pop = 1'b1;
                        for (int w = 0; w < 16; w++) begin
                           for (int j = 0; j < 4; j++) begin
                              byte_pos = 6'(w * 4 + j);
                              if (byte_pos == pos) begin
                                 blk_in[w][j*8 +: 8] = 8'h80;
                              end else if (byte_pos > pos) begin
                                 blk_in[w][j*8 +: 8] = 8'h00;
                              end
                           end
                        end
                        if (pos[5:3] != 3'b111) begin
                           blk_in[14] = bits_ff[31:0];
                           blk_in[15] = bits_ff[63:32];
                           tail_in    = 1'b0;
                        end else begin
                           tail_in    = 1'b1;
                        end
                        a_in     = chain_ff[0];
                        b_in     = chain_ff[1];
                        c_in     = chain_ff[2];
                        d_in     = chain_ff[3];
                        round_in = '0;
                        fin_in   = 1'b1;
                        state_in = S_ROUND;
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         S_ROUND: begin
            a_in     = d_ff;
            b_in     = b_next;
            c_in     = b_ff;
            d_in     = c_ff;
            round_in = round_ff + 1'b1;
            if (round_ff == 6'd63) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            chain_in = sum;
            if (tail_ff) begin
               // extra block holding only the length
               for (int w = 0; w < 16; w++) begin
                  blk_in[w] = '0;
               end
               blk_in[14] = bits_ff[31:0];
               blk_in[15] = bits_ff[63:32];
               a_in       = sum[0];
               b_in       = sum[1];
               c_in       = sum[2];
               d_in       = sum[3];
               round_in   = '0;
               tail_in    = 1'b0;
               state_in   = S_ROUND;
            end else if (fin_ff) begin
               bits_in     = '0;
               finished_in = 1'b1;
               idx_in      = '0;
               state_in    = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               idx_in   = idx_ff + 1'b1;
               if (idx_ff == 2'd3) begin
                  fin_in   = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         chain_ff    <= md5sh_pkg::CHAIN_INIT;
         bits_ff     <= '0;
         finished_ff <= 1'b0;
         round_ff    <= '0;
         tail_ff     <= 1'b0;
         fin_ff      <= 1'b0;
         idx_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         chain_ff    <= chain_in;
         bits_ff     <= bits_in;
         finished_ff <= finished_in;
         round_ff    <= round_in;
         tail_ff     <= tail_in;
         fin_ff      <= fin_in;
         idx_ff      <= idx_in;
      end
   end

   // working variables and block buffer, no reset
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      blk_ff <= blk_in;
   end

   // checks
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND && round_ff == 6'd63) |=> (state_ff == S_ADD))
      else $error("round loop did not end in chain add");

   a_push_state: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (!rsp_full && (state_ff == S_IDLE || state_ff == S_EMIT)))
      else $error("result pushed from wrong state or into full queue");

   a_pop_state: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (!cmd_empty && state_ff == S_IDLE))
      else $error("command popped while busy or empty");

   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (finished_ff && bits_ff == '0))
      else $error("digest emitted before message closed");

   a_emit_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && rsp_push && idx_ff == 2'd3) |=> (state_ff == S_IDLE))
      else $error("digest output did not stop after last word");

endmodule

`default_nettype wire

@@ hdl/md5_stream_hasher.sv @@
// MD5 stream hasher, top level: front end, command queue, back end, result queue.
//
// Message bytes go in one word each; a finish word closes the message and
// yields the four digest words A..D, a restart word opens a new message.
// Data and finish words after finish and before restart each get one reject
// result. A data byte is stored as it is popped; the byte that fills a
// 64-byte block starts the round unit, which does one MD5 round per cycle
// through the 64 rounds, then a chain add, and no word is taken until done.
// A finish pads and hashes the block, plus a length-only block if the length
// spills over, then pushes the four digest words, waiting while the result
// queue is full. A command queue of CMD_DEPTH words sits in front of the back end
// and RSP_DEPTH results wait in the output queue; either side may stall on its own.
`default_nettype none

module md5_stream_hasher #(
   parameter int CMD_DEPTH = md5sh_pkg::CMD_DEPTH_DEFAULT,
   parameter int RSP_DEPTH = md5sh_pkg::RSP_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic             rsp_status,
   output logic [1:0]       rsp_word_index,
   output logic [31:0]      rsp_digest_word,
   output logic             rsp_last_word
);

   localparam int CMD_W = $bits(md5sh_pkg::cmd_type);
   localparam int RSP_W = $bits(md5sh_pkg::rsp_type);

   md5sh_pkg::cmd_type cmd_in_word;
   md5sh_pkg::cmd_type cmd_out_word;
   md5sh_pkg::rsp_type rsp_in_word;
   md5sh_pkg::rsp_type rsp_out_word;
   logic               cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic               rsp_push, rsp_full;
   logic [CMD_W-1:0]   cmd_q_out;
   logic [RSP_W-1:0]   rsp_q_out;

   // input side
   md5sh_front u_front (
      .req_push      (req_push),
      .req_full      (req_full),
      .req_func      (req_func),
      .req_data_byte (req_data_byte),
      .cmd_push      (cmd_push),
      .cmd           (cmd_in_word),
      .cmd_full      (cmd_full)
   );

   md5sh_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_word),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_q_out),
      .empty     (cmd_empty)
   );

   assign cmd_out_word = md5sh_pkg::cmd_type'(cmd_q_out);

   // hashing engine
   md5sh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd_out_word),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_in_word)
   );

   // result side
   md5sh_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in_word),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_q_out),
      .empty     (rsp_empty)
   );

   assign rsp_out_word    = md5sh_pkg::rsp_type'(rsp_q_out);
   assign rsp_status      = rsp_out_word.status;
   assign rsp_word_index  = rsp_out_word.word_index;
   assign rsp_digest_word = rsp_out_word.digest_word;
   assign rsp_last_word   = rsp_out_word.last_word;

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the MD5 stream hasher: message streams in, digest words out.
`default_nettype none

module testbench;

   localparam int RANDOM_ITEMS = 420;
   localparam int STALL_LIMIT  = 5000;   // cycles with no word moving on either side
   localparam int SETTLE_CYCLES = 200;   // longer than a two-block finish

   // Per-round additive constants
   localparam logic [31:0] SINE_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Left-rotate per {group, round mod 4}
   localparam int unsigned MD5_SHIFT [16] = '{
      7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
   };

   // Receiver pop patterns
   typedef enum logic [1:0] {
      DRAIN_ALL, DRAIN_COIN, DRAIN_EVERY_FIFTH, DRAIN_SPARSE
   } drain_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic [1:0]  req_func = md5sh_pkg::CMD_DATA;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_pop = 1'b0;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_status;
   logic [1:0]  rsp_word_index;
   logic [31:0] rsp_digest_word;
   logic        rsp_last_word;

   // Predicted hash state
   logic [31:0] chain_q [4];
   logic [31:0] block_q [16];
   logic [63:0] msg_bits;
   logic        msg_closed;

   md5sh_pkg::rsp_type pending_digest [$];
   md5sh_pkg::rsp_type want_word;
   int          error_count = 0;
   int          items_sent = 0;
   int          stall_cycles = 0;

   // Sender burst state
   int          burst_left = 1;
   bit          steady_flow = 1'b0;

   // Receiver pattern state
   drain_mode_type drain_mode = DRAIN_ALL;
   int          drain_hold = 0;
   int          drain_phase = 0;

   md5_stream_hasher dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_func        (req_func),
      .req_data_byte   (req_data_byte),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_status      (rsp_status),
      .rsp_word_index  (rsp_word_index),
      .rsp_digest_word (rsp_digest_word),
      .rsp_last_word   (rsp_last_word)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void md5_init();
      int k;
      chain_q[0] = 32'h67452301;
      chain_q[1] = 32'hefcdab89;
      chain_q[2] = 32'h98badcfe;
      chain_q[3] = 32'h10325476;
      for (k = 0; k < 16; k++) block_q[k] = '0;
      msg_bits = '0;
      msg_closed = 1'b0;
   endfunction

   function automatic void md5_compress();
      logic [31:0] a, b, c, d, f, t, r;
      int unsigned i, g, grp, s;
      a = chain_q[0];
      b = chain_q[1];
      c = chain_q[2];
      d = chain_q[3];
      for (i = 0; i < 64; i++) begin
         grp = i / 16;
         case (grp)
            0: begin
               f = d ^ (b & (c ^ d));
               g = i;
            end
            1: begin
               f = c ^ (d & (b ^ c));
               g = (5 * i + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * i + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * i) % 16;
            end
         endcase
         t = a + f + block_q[g] + SINE_K[i];
         s = MD5_SHIFT[grp * 4 + i % 4];
         r = (t << s) | (t >> (32 - s));
         a = d;
         d = c;
         c = b;
         b = b + r;
      end
      chain_q[0] = chain_q[0] + a;
      chain_q[1] = chain_q[1] + b;
      chain_q[2] = chain_q[2] + c;
      chain_q[3] = chain_q[3] + d;
   endfunction

   // Little-endian byte lane within the 16-word block
   function automatic void put_byte(int unsigned pos, logic [7:0] v);
      block_q[pos / 4][(pos % 4) * 8 +: 8] = v;
   endfunction

   // Advance the hash state by one accepted word and queue its results
   function automatic void md5_predict(logic [1:0] fn, logic [7:0] b);
      md5sh_pkg::rsp_type e;
      int unsigned pos;
      int          k;
      case (fn)
         md5sh_pkg::CMD_RESTART: md5_init();
         md5sh_pkg::CMD_UNUSED: ;
         default: begin
            if (msg_closed) begin
               e.status      = md5sh_pkg::STATUS_REJECT;
               e.word_index  = 2'd0;
               e.digest_word = 32'h0;
               e.last_word   = 1'b1;
               pending_digest.push_back(e);
            end else begin
               pos = msg_bits[8:3];
               if (fn == md5sh_pkg::CMD_DATA) begin
                  put_byte(pos, b);
                  msg_bits = msg_bits + 64'd8;
                  if (pos == 63) md5_compress();
               end else begin
                  // pad, spill into a second block when the length won't fit
                  put_byte(pos, 8'h80);
                  for (k = pos + 1; k < 64; k++) put_byte(k, 8'h00);
                  if (pos >= 56) begin
                     md5_compress();
                     for (k = 0; k < 16; k++) block_q[k] = '0;
                  end
                  block_q[14] = msg_bits[31:0];
                  block_q[15] = msg_bits[63:32];
                  md5_compress();
                  msg_bits = '0;
                  msg_closed = 1'b1;
                  for (k = 0; k < 4; k++) begin
                     e.status      = md5sh_pkg::STATUS_OK;
                     e.word_index  = 2'(k);
                     e.digest_word = chain_q[k];
                     e.last_word   = (k == 3);
                     pending_digest.push_back(e);
                  end
               end
            end
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- driving

   // Push one word, hold until accepted, then maybe open a gap
   task automatic send_word(input logic [1:0] fn, input logic [7:0] b);
      req_push      <= 1'b1;
      req_func      <= fn;
      req_data_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      md5_predict(fn, b);
      if (fn != md5sh_pkg::CMD_UNUSED) items_sent++;
      burst_left = burst_left - 1;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         if (!steady_flow) begin
            req_push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   endtask

   // Stop pushing until every predicted word has come back
   task automatic wait_results_drained();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_digest.size() != 0);
   endtask

   task automatic send_message(input int len);
      int i;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 39) == 0)
            send_word(md5sh_pkg::CMD_UNUSED, 8'($urandom_range(0, 255)));
         send_word(md5sh_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
      end
      send_word(md5sh_pkg::CMD_FINISH, 8'($urandom_range(0, 255)));
   endtask

   // Receiver: pop pattern is re-chosen at random once its hold count runs out
   always @(posedge clock) begin
      if (drain_hold == 0) begin
         drain_mode <= drain_mode_type'($urandom_range(0, 3));
         drain_hold <= $urandom_range(20, 300);
      end else begin
         drain_hold <= drain_hold - 1;
      end
      case (drain_mode)
         DRAIN_ALL:         rsp_pop <= 1'b1;
         DRAIN_COIN:        rsp_pop <= 1'($urandom_range(0, 1));
         DRAIN_EVERY_FIFTH: rsp_pop <= (drain_phase % 5 == 0);
         default:           rsp_pop <= ($urandom_range(0, 7) == 0);
      endcase
      drain_phase <= drain_phase + 1;
   end

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_digest.size() == 0) begin
            $error("unexpected result word: status %0d index %0d word %h",
                   rsp_status, rsp_word_index, rsp_digest_word);
            error_count++;
         end else begin
            want_word = pending_digest.pop_front();
            if (rsp_status !== want_word.status) begin
               $error("rsp_status: expected %0d, got %0d", want_word.status, rsp_status);
               error_count++;
            end
            if (rsp_word_index !== want_word.word_index) begin
               $error("rsp_word_index: expected %0d, got %0d",
                      want_word.word_index, rsp_word_index);
               error_count++;
            end
            if (rsp_digest_word !== want_word.digest_word) begin
               $error("rsp_digest_word: expected %h, got %h",
                      want_word.digest_word, rsp_digest_word);
               error_count++;
            end
            if (rsp_last_word !== want_word.last_word) begin
               $error("rsp_last_word: expected %0d, got %0d",
                      want_word.last_word, rsp_last_word);
               error_count++;
            end
         end
      end
   end

   // Watchdog: nothing moving for too long means a hang
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles = stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // Empty message, then everything a closed message must reject or ignore
   task automatic test_closed_message();
      send_word(md5sh_pkg::CMD_FINISH, 8'h00);
      send_word(md5sh_pkg::CMD_FINISH, 8'hFF);
      send_word(md5sh_pkg::CMD_DATA, 8'hFF);
      send_word(md5sh_pkg::CMD_UNUSED, 8'h5A);
      send_word(md5sh_pkg::CMD_RESTART, 8'h00);
      send_word(md5sh_pkg::CMD_RESTART, 8'hFF);
   endtask

   // Byte extremes, "abc", and a message abandoned halfway
   task automatic test_short_messages();
      send_word(md5sh_pkg::CMD_DATA, 8'h00);
      send_word(md5sh_pkg::CMD_DATA, 8'hFF);
      send_word(md5sh_pkg::CMD_FINISH, 8'hA5);
      send_word(md5sh_pkg::CMD_RESTART, 8'h3C);
      send_word(md5sh_pkg::CMD_DATA, 8'h61);
      send_word(md5sh_pkg::CMD_DATA, 8'h62);
      send_word(md5sh_pkg::CMD_DATA, 8'h63);
      send_word(md5sh_pkg::CMD_FINISH, 8'h00);
      send_word(md5sh_pkg::CMD_RESTART, 8'h00);
      send_word(md5sh_pkg::CMD_DATA, 8'h11);
      send_word(md5sh_pkg::CMD_UNUSED, 8'hFF);
      send_word(md5sh_pkg::CMD_RESTART, 8'hC3);
      send_word(md5sh_pkg::CMD_DATA, 8'hA5);
      send_word(md5sh_pkg::CMD_FINISH, 8'hFF);
      send_word(md5sh_pkg::CMD_RESTART, 8'h00);
   endtask

   // Random messages, weighted toward the padding boundaries
   task automatic test_random_messages();
      int start_count, len, msg_no, i;
      start_count = items_sent;
      msg_no = 0;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         steady_flow = ($urandom_range(0, 3) == 0);
         case (msg_no)
            0: len = 55;
            1: len = 56;
            2: len = 63;
            3: len = 64;
            default: begin
               i = $urandom_range(0, 99);
               if (i < 50) begin
                  len = $urandom_range(0, 20);
               end else if (i < 85) begin
                  case ($urandom_range(0, 7))
                     0: len = 55;
                     1: len = 56;
                     2: len = 57;
                     3: len = 63;
                     4: len = 64;
                     5: len = 65;
                     6: len = 119;
                     default: len = 120;
                  endcase
               end else begin
                  len = $urandom_range(21, 130);
               end
            end
         endcase
         if (msg_no >= 4 && $urandom_range(0, 9) == 0) begin
            // message dropped by a restart before finish
            for (i = 0; i < len / 2; i++)
               send_word(md5sh_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
            send_word(md5sh_pkg::CMD_RESTART, 8'($urandom_range(0, 255)));
         end else begin
            send_message(len);
            repeat ($urandom_range(0, 2))
               send_word($urandom_range(0, 1) ? md5sh_pkg::CMD_DATA : md5sh_pkg::CMD_FINISH,
                         8'($urandom_range(0, 255)));
            if (msg_no == 1 || $urandom_range(0, 7) == 0) wait_results_drained();
            send_word(md5sh_pkg::CMD_RESTART, 8'($urandom_range(0, 255)));
         end
         msg_no++;
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      md5_init();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_closed_message();
      test_short_messages();
      test_random_messages();
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/md5sh_pkg.sv
hdl/md5sh_fifo.sv
hdl/md5sh_front.sv
hdl/md5sh_back.sv
hdl/md5_stream_hasher.sv
dv/testbench.sv
